// File: design/mmb_pkg.sv
// Shared types, constants and arithmetic helpers of the model matrix builder.
package mmb_pkg;

  localparam int DefCordicSteps = 16;
  localparam int AtanEntries    = 24;
  localparam int FracBits       = 16;
  localparam int AngShift       = 18;
  localparam int ZW             = 35;
  localparam int CW             = 33;
  localparam int PW             = 34;

  typedef logic signed [31:0] word_t;
  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [ZW-1:0] zwide_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef enum logic [1:0] {
    Row0 = 2'd0,
    Row1 = 2'd1,
    Row2 = 2'd2,
    Row3 = 2'd3
  } row_e;

  localparam zwide_t QPi       = 35'sd3373259426;
  localparam zwide_t QHalfPi   = 35'sd1686629713;
  localparam zwide_t QTwoPi    = 35'sd6746518852;
  localparam cval_t  CordicGain = 33'sd652032874;
  localparam cval_t  QOneC     = 33'sd1073741824;
  localparam word_t  QOneW     = 32'sd1073741824;
  localparam word_t  OneQ      = word_t'(64'sd1 <<< FracBits);

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
    logic  flip;
  } lane_t;

  typedef struct packed {
    lane_t ax;
    lane_t ay;
  } lanes_t;

  typedef struct packed {
    word_t scale;
    word_t shift_x;
    word_t shift_y;
    word_t shift_z;
  } side_t;

  typedef struct packed {
    word_t sx;
    word_t cx;
    word_t sy;
    word_t cy;
  } trig_t;

  typedef struct packed {
    word_t sxsy;
    word_t sxcy;
    word_t cxsy;
    word_t cxcy;
    word_t cx;
    word_t cy;
    word_t nsx;
    word_t nsy;
  } trp_t;

  typedef struct packed {
    prod_t m00;
    prod_t m02;
    prod_t m10;
    prod_t m11;
    prod_t m12;
    prod_t m20;
    prod_t m21;
    prod_t m22;
  } mat_t;

  function automatic cval_t atan_q30(input int idx);
    case (idx)
      0:       return 33'sd843314856;
      1:       return 33'sd497837829;
      2:       return 33'sd263043836;
      3:       return 33'sd133525158;
      4:       return 33'sd67021686;
      5:       return 33'sd33543515;
      6:       return 33'sd16775850;
      7:       return 33'sd8388437;
      8:       return 33'sd4194282;
      9:       return 33'sd2097149;
      10:      return 33'sd1048575;
      11:      return 33'sd524287;
      12:      return 33'sd262143;
      13:      return 33'sd131071;
      14:      return 33'sd65535;
      15:      return 33'sd32767;
      16:      return 33'sd16383;
      17:      return 33'sd8191;
      18:      return 33'sd4095;
      19:      return 33'sd2047;
      20:      return 33'sd1023;
      21:      return 33'sd511;
      22:      return 33'sd255;
      23:      return 33'sd127;
      default: return '0;
    endcase
  endfunction

  // round half up to Q.30, floor shift
  function automatic prod_t mul_q30(input word_t a, input word_t b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return p[63:30];
  endfunction

  function automatic word_t sat32(input prod_t v);
    if (v > 34'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// File: design/mmb_reduce.sv
// Two-stage angle range reduction and CORDIC seed for both rotation angles.
module mmb_reduce (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [15:0]     angle_x_i,
  input  logic [15:0]     angle_y_i,
  input  mmb_pkg::side_t  side_i,
  output logic            valid_o,
  output mmb_pkg::lanes_t lanes_o,
  output mmb_pkg::side_t  side_o
);
  import mmb_pkg::*;

  function automatic zwide_t fold_full(input logic [15:0] a);
    zwide_t z;
    z = {{(ZW-16-AngShift){a[15]}}, a, {AngShift{1'b0}}};
    if (z > QPi) begin
      return z - QTwoPi;
    end else if (z < -QPi) begin
      return z + QTwoPi;
    end
    return z;
  endfunction

  function automatic lane_t fold_half(input zwide_t z);
    lane_t  l;
    zwide_t zr;
    l.x    = CordicGain;
    l.y    = '0;
    l.flip = 1'b0;
    zr     = z;
    if (z > QHalfPi) begin
      zr     = z - QPi;
      l.flip = 1'b1;
    end else if (z < -QHalfPi) begin
      zr     = z + QPi;
      l.flip = 1'b1;
    end
    l.z = cval_t'(zr);
    return l;
  endfunction

  logic   va_q, vb_q;
  zwide_t zx_q, zy_q;
  side_t  sa_q, sb_q;
  lanes_t lanes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zx_q       <= fold_full(angle_x_i);
      zy_q       <= fold_full(angle_y_i);
      sa_q       <= side_i;
      lanes_q.ax <= fold_half(zx_q);
      lanes_q.ay <= fold_half(zy_q);
      sb_q       <= sa_q;
    end
  end

  assign valid_o = vb_q;
  assign lanes_o = lanes_q;
  assign side_o  = sb_q;

endmodule

// File: design/mmb_cordic_cell.sv
// One CORDIC rotation step for both angles, registered, with side data carried along.
module mmb_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  mmb_pkg::lanes_t lanes_i,
  input  mmb_pkg::side_t  side_i,
  output logic            valid_o,
  output mmb_pkg::lanes_t lanes_o,
  output mmb_pkg::side_t  side_o
);
  import mmb_pkg::*;

  localparam cval_t Atan = atan_q30(STEP);

  function automatic lane_t rotate(input lane_t l);
    lane_t r;
    r.flip = l.flip;
    if (l.z >= 0) begin
      r.x = l.x - (l.y >>> STEP);
      r.y = l.y + (l.x >>> STEP);
      r.z = l.z - Atan;
    end else begin
      r.x = l.x + (l.y >>> STEP);
      r.y = l.y - (l.x >>> STEP);
      r.z = l.z + Atan;
    end
    return r;
  endfunction

  logic   valid_q;
  lanes_t lanes_q;
  side_t  side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_q.ax <= rotate(lanes_i.ax);
      lanes_q.ay <= rotate(lanes_i.ay);
      side_q     <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;
  assign side_o  = side_q;

endmodule

// File: design/mmb_matrix_prod.sv
// Trig fix-up, trig cross products and scale products of the matrix entries.
module mmb_matrix_prod (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  mmb_pkg::lanes_t lanes_i,
  input  mmb_pkg::side_t  side_i,
  output logic            valid_o,
  output mmb_pkg::mat_t   mat_o,
  output mmb_pkg::side_t  side_o
);
  import mmb_pkg::*;

  function automatic word_t trig_fix(input cval_t v, input logic flip);
    cval_t t;
    t = flip ? -v : v;
    if (t > QOneC) begin
      return QOneW;
    end else if (t < -QOneC) begin
      return -QOneW;
    end
    return word_t'(t);
  endfunction

  logic  vf_q, vt_q, vs_q;
  trig_t tf_q;
  trp_t  tp_q;
  mat_t  mat_q;
  side_t sf_q, st_q, ss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
      vt_q <= 1'b0;
      vs_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= valid_i;
      vt_q <= vf_q;
      vs_q <= vt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tf_q.sx <= trig_fix(lanes_i.ax.y, lanes_i.ax.flip);
      tf_q.cx <= trig_fix(lanes_i.ax.x, lanes_i.ax.flip);
      tf_q.sy <= trig_fix(lanes_i.ay.y, lanes_i.ay.flip);
      tf_q.cy <= trig_fix(lanes_i.ay.x, lanes_i.ay.flip);
      sf_q    <= side_i;

      tp_q.sxsy <= word_t'(mul_q30(tf_q.sx, tf_q.sy));
      tp_q.sxcy <= word_t'(mul_q30(tf_q.sx, tf_q.cy));
      tp_q.cxsy <= word_t'(mul_q30(tf_q.cx, tf_q.sy));
      tp_q.cxcy <= word_t'(mul_q30(tf_q.cx, tf_q.cy));
      tp_q.cx   <= tf_q.cx;
      tp_q.cy   <= tf_q.cy;
      tp_q.nsx  <= -tf_q.sx;
      tp_q.nsy  <= -tf_q.sy;
      st_q      <= sf_q;

      mat_q.m00 <= mul_q30(st_q.scale, tp_q.cy);
      mat_q.m02 <= mul_q30(st_q.scale, tp_q.nsy);
      mat_q.m10 <= mul_q30(st_q.scale, tp_q.sxsy);
      mat_q.m11 <= mul_q30(st_q.scale, tp_q.cx);
      mat_q.m12 <= mul_q30(st_q.scale, tp_q.sxcy);
      mat_q.m20 <= mul_q30(st_q.scale, tp_q.cxsy);
      mat_q.m21 <= mul_q30(st_q.scale, tp_q.nsx);
      mat_q.m22 <= mul_q30(st_q.scale, tp_q.cxcy);
      ss_q      <= st_q;
    end
  end

  assign valid_o = vs_q;
  assign mat_o   = mat_q;
  assign side_o  = ss_q;

endmodule

// File: design/model_matrix_builder_unit.sv
// Top level: scale/rotate/translate model matrix builder with CORDIC cell chain and row output.
//
// Each input transaction yields four output transactions, rows 0 to 3 of the row-major
// matrix S*Rx*Ry*T, the last one flagged by last_row_o. The pipeline takes a new input
// transaction every cycle while it can move; the four-row output register limits the
// sustained rate, since it takes a new matrix only once its last row is taken. On its
// way to the first row, an input passes two range reduction stages, one cell per CORDIC
// step, three product stages and the output register. A stall on the
// output freezes the whole pipeline once its tail holds a finished matrix.
module model_matrix_builder_unit #(
  parameter int CORDIC_STEPS = mmb_pkg::DefCordicSteps
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [31:0]  scale_i,
  input  logic [15:0]  angle_x_i,
  input  logic [15:0]  angle_y_i,
  input  logic [31:0]  shift_x_i,
  input  logic [31:0]  shift_y_i,
  input  logic [31:0]  shift_z_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [1:0]   row_index_o,
  output logic [31:0]  col0_o,
  output logic [31:0]  col1_o,
  output logic [31:0]  col2_o,
  output logic [31:0]  col3_o,
  output logic         last_row_o
);
  import mmb_pkg::*;

  logic   adv;
  logic   ser_free;
  side_t  side_in;

  logic   valid_c [CORDIC_STEPS+1];
  lanes_t lanes_c [CORDIC_STEPS+1];
  side_t  side_c  [CORDIC_STEPS+1];

  logic   prod_valid;
  mat_t   prod_mat;
  side_t  prod_side;

  logic   ser_valid_q;
  row_e   row_q;
  mat_t   mat_q;
  side_t  side_q;

  assign side_in.scale   = scale_i;
  assign side_in.shift_x = shift_x_i;
  assign side_in.shift_y = shift_y_i;
  assign side_in.shift_z = shift_z_i;

  assign ser_free   = !ser_valid_q || (row_q == Row3 && !out_stall_i);
  assign adv        = ser_free || !prod_valid;
  assign in_stall_o = !adv;

  mmb_reduce u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (in_valid_i),
    .angle_x_i (angle_x_i),
    .angle_y_i (angle_y_i),
    .side_i    (side_in),
    .valid_o   (valid_c[0]),
    .lanes_o   (lanes_c[0]),
    .side_o    (side_c[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    mmb_cordic_cell #(
      .STEP (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (valid_c[g]),
      .lanes_i (lanes_c[g]),
      .side_i  (side_c[g]),
      .valid_o (valid_c[g+1]),
      .lanes_o (lanes_c[g+1]),
      .side_o  (side_c[g+1])
    );
  end

  mmb_matrix_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (valid_c[CORDIC_STEPS]),
    .lanes_i (lanes_c[CORDIC_STEPS]),
    .side_i  (side_c[CORDIC_STEPS]),
    .valid_o (prod_valid),
    .mat_o   (prod_mat),
    .side_o  (prod_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      row_q       <= Row0;
    end else if (ser_free) begin
      ser_valid_q <= prod_valid;
      row_q       <= Row0;
    end else if (!out_stall_i) begin
      row_q <= row_e'(row_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_free) begin
      mat_q  <= prod_mat;
      side_q <= prod_side;
    end
  end

  always_comb begin
    case (row_q)
      Row0: begin
        col0_o = sat32(mat_q.m00);
        col1_o = '0;
        col2_o = sat32(mat_q.m02);
        col3_o = '0;
      end
      Row1: begin
        col0_o = sat32(mat_q.m10);
        col1_o = sat32(mat_q.m11);
        col2_o = sat32(mat_q.m12);
        col3_o = '0;
      end
      Row2: begin
        col0_o = sat32(mat_q.m20);
        col1_o = sat32(mat_q.m21);
        col2_o = sat32(mat_q.m22);
        col3_o = '0;
      end
      Row3: begin
        col0_o = side_q.shift_x;
        col1_o = side_q.shift_y;
        col2_o = side_q.shift_z;
        col3_o = OneQ;
      end
      default: begin
        col0_o = '0;
        col1_o = '0;
        col2_o = '0;
        col3_o = '0;
      end
    endcase
  end

  assign out_valid_o = ser_valid_q;
  assign row_index_o = row_q;
  assign last_row_o  = (row_q == Row3);

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_row_o) |=>
      (out_valid_o && row_index_o == 2'($past(row_index_o) + 2'd1)))
    else $error("row sequence broken after a taken row");

  a_matrix_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (row_index_o == Row0))
    else $error("matrix does not start at row 0");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && prod_valid) |-> in_stall_o)
    else $error("input taken while the pipeline tail is blocked");

  a_stall_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(row_index_o)))
    else $error("row advanced under output stall");

endmodule
